FILE: src/parking_distance_zone_indicator_unit_defines.svh
// ----------------------------------------------------------------------------
// Parking distance zone indicator: assertion macros
// Shared property wrappers, clocked on aclk and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef PARKING_DISTANCE_ZONE_INDICATOR_UNIT_DEFINES_SVH
`define PARKING_DISTANCE_ZONE_INDICATOR_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define PDZI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PDZI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pdzi_pkg.sv
// ----------------------------------------------------------------------------
// pdzi_pkg
// Types, zone codes and bound arithmetic shared by the zone indicator.
// ----------------------------------------------------------------------------
package pdzi_pkg;

    localparam int DIST_W  = 12;
    localparam int POT_W   = 10;
    localparam int LIMIT_W = 18;
    localparam int ZONE_W  = 3;
    localparam int LED_W   = 5;

    localparam logic [DIST_W-1:0]  MID_BASE    = 12'd1046;
    localparam logic [POT_W-1:0]   POT_RESET   = 10'd334;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd180000;
    localparam logic [LIMIT_W-1:0] IDLE_MAX    = 18'd262143;

    // register indexes on the config port
    localparam logic CFG_POT   = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // item kinds carried on s_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [ZONE_W-1:0] ZONE_OFF       = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_TOO_CLOSE = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_CLOSE     = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_OPTIMAL   = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_FAR       = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_TOO_FAR   = 3'd5;

    // floor(k*m/5) = (m * k*ceil(2^17/5)) >> 17, floor(k*m/25) likewise with 2^21,
    // exact for every midpoint the trim range allows
    localparam int MUL_W = 36;
    localparam logic [MUL_W-1:0] K_B1 = 36'd104860;   // 4  * 26215
    localparam logic [MUL_W-1:0] K_B2 = 36'd2013288;  // 24 * 83887
    localparam logic [MUL_W-1:0] K_B3 = 36'd2181062;  // 26 * 83887
    localparam logic [MUL_W-1:0] K_B4 = 36'd157290;   // 6  * 26215

    typedef struct packed {
        logic [DIST_W-1:0] b1;
        logic [DIST_W-1:0] b2;
        logic [DIST_W-1:0] b3;
        logic [DIST_W-1:0] b4;
    } pdzi_bounds_t;

    typedef struct packed {
        pdzi_bounds_t       bounds;
        logic [LIMIT_W-1:0] limit;
    } pdzi_cfg_t;

    typedef struct packed {
        logic              cmd;
        logic              switch_pressed;
        logic [DIST_W-1:0] distance;
    } pdzi_item_t;

    function automatic pdzi_bounds_t pdzi_calc_bounds(input logic [POT_W-1:0] pot);
        logic [MUL_W-1:0] mid;
        logic [MUL_W-1:0] p1;
        logic [MUL_W-1:0] p2;
        logic [MUL_W-1:0] p3;
        logic [MUL_W-1:0] p4;
        pdzi_bounds_t     b;
        mid  = MUL_W'(MID_BASE) + MUL_W'(pot);
        p1   = mid * K_B1;
        p2   = mid * K_B2;
        p3   = mid * K_B3;
        p4   = mid * K_B4;
        b.b1 = p1[17 +: DIST_W];
        b.b2 = p2[21 +: DIST_W];
        b.b3 = p3[21 +: DIST_W];
        b.b4 = p4[17 +: DIST_W];
        return b;
    endfunction

endpackage

FILE: src/pdzi_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdzi_cfg_regs
// Config registers; the zone bounds are worked out once per trim write.
// ----------------------------------------------------------------------------
module pdzi_cfg_regs import pdzi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    output pdzi_cfg_t          cfg
);

    pdzi_bounds_t       bounds_reg;
    pdzi_bounds_t       bounds_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;

    always_comb begin
        bounds_next = bounds_reg;
        limit_next  = limit_reg;
        if (cfg_wen) begin
            unique case (cfg_index)
                CFG_POT:   bounds_next = pdzi_calc_bounds(cfg_wdata[POT_W-1:0]);
                CFG_LIMIT: limit_next  = cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg <= pdzi_calc_bounds(POT_RESET);
            limit_reg  <= LIMIT_RESET;
        end else begin
            bounds_reg <= bounds_next;
            limit_reg  <= limit_next;
        end
    end

    assign cfg.bounds = bounds_reg;
    assign cfg.limit  = limit_reg;

endmodule

FILE: src/pdzi_in_reg.sv
// ----------------------------------------------------------------------------
// pdzi_in_reg
// Input register: holds one beat until the core takes it.
// ----------------------------------------------------------------------------
module pdzi_in_reg import pdzi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  pdzi_item_t s_item,
    output logic       item_valid,
    output pdzi_item_t item,
    input  logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    pdzi_item_t item_reg;
    logic       load;

    // refill in the same cycle the core drains
    assign s_tready   = !valid_reg || item_take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: src/pdzi_core.sv
// ----------------------------------------------------------------------------
// pdzi_core
// Sample averaging, zone classification, idle timer and result register.
// ----------------------------------------------------------------------------
module pdzi_core import pdzi_pkg::*; #(
    parameter int AVG_COUNT = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdzi_cfg_t         cfg,
    input  logic              item_valid,
    input  pdzi_item_t        item,
    output logic              item_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ZONE_W-1:0] out_zone,
    output logic [LED_W-1:0]  out_led,
    output logic [DIST_W-1:0] out_avg,
    output logic              powered_off
);

    localparam int SUM_W   = $clog2(AVG_COUNT * 4096);
    localparam int CNT_W   = $clog2(AVG_COUNT + 1);
    localparam int RK      = SUM_W + 5;
    localparam int RECIP_W = RK + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**RK + AVG_COUNT - 1) / AVG_COUNT);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(AVG_COUNT);

    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] idle_reg,  idle_next;
    logic               off_reg,   off_next;
    logic [ZONE_W-1:0]  last_reg,  last_next;
    logic               ovalid_reg, ovalid_next;
    logic [ZONE_W-1:0]  ozone_reg, ozone_next;
    logic [LED_W-1:0]   oled_reg,  oled_next;
    logic [DIST_W-1:0]  oavg_reg,  oavg_next;

    logic [SUM_W-1:0]  total;
    logic [CNT_W-1:0]  count_inc;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] avg;
    logic [ZONE_W-1:0] zone;
    logic [LED_W-1:0]  led;
    logic              complete;
    logic              post;

    // take a beat whenever the result register has room for its result
    assign item_take = item_valid && (!ovalid_reg || out_ready);

    assign total     = sum_reg + SUM_W'(item.distance);
    assign count_inc = count_reg + 1'b1;
    assign complete  = (count_inc == CNT_LAST);
    assign prod      = PROD_W'(total) * PROD_W'(RECIP);
    assign avg       = prod[RK +: DIST_W];

    always_comb begin
        if (avg < cfg.bounds.b1) begin
            zone = ZONE_TOO_CLOSE;
        end else if (avg < cfg.bounds.b2) begin
            zone = ZONE_CLOSE;
        end else if (avg < cfg.bounds.b3) begin
            zone = ZONE_OPTIMAL;
        end else if (avg < cfg.bounds.b4) begin
            zone = ZONE_FAR;
        end else begin
            zone = ZONE_TOO_FAR;
        end
    end

    always_comb begin
        unique case (zone)
            ZONE_TOO_CLOSE: led = 5'b00001;
            ZONE_CLOSE:     led = 5'b00010;
            ZONE_OPTIMAL:   led = 5'b00100;
            ZONE_FAR:       led = 5'b01000;
            ZONE_TOO_FAR:   led = 5'b10000;
            default:        led = '0;
        endcase
    end

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        off_next   = off_reg;
        last_next  = last_reg;
        post       = 1'b0;
        ozone_next = ozone_reg;
        oled_next  = oled_reg;
        oavg_next  = oavg_reg;
        if (item_take) begin
            if (item.cmd == CMD_TICK) begin
                if (idle_reg != IDLE_MAX) begin
                    idle_next = idle_reg + 1'b1;
                end
            end else if (off_reg) begin
                // wake beat is consumed without a result
                if (item.distance != '0 || item.switch_pressed) begin
                    off_next  = 1'b0;
                    idle_next = '0;
                end
            end else if (!complete) begin
                sum_next   = total;
                count_next = count_inc;
            end else begin
                sum_next   = '0;
                count_next = '0;
                post       = 1'b1;
                oavg_next  = avg;
                if (idle_reg > cfg.limit) begin
                    off_next   = 1'b1;
                    ozone_next = ZONE_OFF;
                    oled_next  = '0;
                end else begin
                    ozone_next = zone;
                    oled_next  = led;
                    if (zone != last_reg) begin
                        last_next = zone;
                        idle_next = '0;
                    end
                end
            end
        end
        ovalid_next = post || (ovalid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            count_reg  <= '0;
            idle_reg   <= '0;
            off_reg    <= 1'b0;
            last_reg   <= ZONE_OFF;
            ovalid_reg <= 1'b0;
        end else begin
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            idle_reg   <= idle_next;
            off_reg    <= off_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ozone_reg <= ozone_next;
        oled_reg  <= oled_next;
        oavg_reg  <= oavg_next;
    end

    assign out_valid   = ovalid_reg;
    assign out_zone    = ozone_reg;
    assign out_led     = oled_reg;
    assign out_avg     = oavg_reg;
    assign powered_off = off_reg;

endmodule

FILE: src/parking_distance_zone_indicator_unit.sv
// Path: a beat is registered in the input register, then processed by the core; a group's
//   result is registered in the result register when the core takes its last sample beat.
// Throughput: one beat per cycle while m_tready stays high; one averaging
//   multiply and four bound compares sit between the input and result registers.
// Reset: aresetn is synchronous, active low; clears the sums, idle timer and
//   power state, and restores the trim (334) and idle limit (180000 ms).
// ----------------------------------------------------------------------------
// parking_distance_zone_indicator_unit
// Averages distance samples in groups and sorts each mean into a parking zone,
// powering off after a configurable idle time.
// ----------------------------------------------------------------------------
`include "parking_distance_zone_indicator_unit_defines.svh"

module parking_distance_zone_indicator_unit import pdzi_pkg::*; #(
    parameter int AVG_COUNT = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [11:0] distance, [12] switch_pressed
    input  logic               s_tuser,   // [0] cmd
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata    // [2:0] zone, [7:3] led_pattern,
                                          // [19:8] average_distance
);

    pdzi_cfg_t         cfg;
    pdzi_item_t        s_item;
    pdzi_item_t        item;
    logic              item_valid;
    logic              item_take;
    logic [ZONE_W-1:0] out_zone;
    logic [LED_W-1:0]  out_led;
    logic [DIST_W-1:0] out_avg;
    logic              powered_off;

    assign s_item.cmd            = s_tuser;
    assign s_item.distance       = s_tdata[DIST_W-1:0];
    assign s_item.switch_pressed = s_tdata[DIST_W];

    pdzi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdzi_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    pdzi_core #(
        .AVG_COUNT (AVG_COUNT)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_zone    (out_zone),
        .out_led     (out_led),
        .out_avg     (out_avg),
        .powered_off (powered_off)
    );

    assign m_tdata = {4'b0000, out_avg, out_led, out_zone};

    `PDZI_ASSERT_SAME(a_led_onehot, m_tvalid && out_zone != ZONE_OFF, $onehot(out_led), "lamp drive not one-hot for an active zone")
    `PDZI_ASSERT_SAME(a_led_dark_off, m_tvalid && out_zone == ZONE_OFF, out_led == '0, "lamp drive set while reporting off")
    `PDZI_ASSERT_SAME(a_off_posts, $rose(powered_off), m_tvalid && out_zone == ZONE_OFF, "power-off without an off result")
    `PDZI_ASSERT_NEXT(a_take_valid, item_take, $past(item_valid), "core took an empty input register")

endmodule
